>>> design/pus_telecommand_check_and_ack_unit_assert.svh
// Assertion macros shared by the telecommand check and acknowledge unit.
`ifndef PUS_TELECOMMAND_CHECK_AND_ACK_UNIT_ASSERT_SVH
`define PUS_TELECOMMAND_CHECK_AND_ACK_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define PUSTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A transfer that waits on ready keeps valid high and its payload steady.
`define PUSTC_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

>>> design/pustc_pkg.sv
package pustc_pkg;

  localparam int unsigned TmBytes = 14;
  localparam int unsigned IdxW    = $clog2(TmBytes + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [10:0] TmApidReset = 11'd812;
  localparam logic [7:0]  TmDestReset = 8'd120;

  localparam logic [7:0] TmLenHi  = 8'h00;
  localparam logic [7:0] TmLenLo  = 8'h07;
  localparam logic [7:0] TmHdr0   = 8'h10;
  localparam logic [7:0] TmHdr1   = 8'h01;
  localparam logic [7:0] TmHdr2   = 8'h01;

  // Header layout of the telecommand, in byte positions.
  localparam logic [16:0] PosSeq    = 17'd2;
  localparam logic [16:0] PosLen    = 17'd4;
  localparam logic [16:0] PosHdr    = 17'd6;
  localparam logic [16:0] PosData   = 17'd10;
  localparam logic [15:0] MinLen    = 16'd5;
  localparam logic [16:0] ShortSize = 17'd12;
  localparam logic [16:0] SizeExtra = 17'd7;

  typedef enum logic {
    CFG_TM_APID = 1'b0,
    CFG_TM_DEST = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_TM     = 1'b1
  } out_kind_e;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] seq;
    logic [27:0] fhdr;
    logic        crc_ok;
    logic [15:0] crc;
  } report_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> design/pustc_byte_if.sv
interface pustc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tc_byte;

  modport source (output valid, output tc_byte, input ready);
  modport sink (input valid, input tc_byte, output ready);
endinterface

>>> design/pustc_res_if.sv
interface pustc_res_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tm_byte;
  logic [10:0] apid;
  logic [1:0]  seq_flags;
  logic [13:0] seq_count;
  logic [3:0]  ack_flags;
  logic [7:0]  service_type;
  logic [7:0]  service_subtype;
  logic [7:0]  src_ident;
  logic        crc_ok;
  logic [15:0] computed_crc;
  logic        last_of_run;

  modport source (
    output valid, output out_kind, output tm_byte, output apid, output seq_flags,
    output seq_count, output ack_flags, output service_type, output service_subtype,
    output src_ident, output crc_ok, output computed_crc, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input out_kind, input tm_byte, input apid, input seq_flags,
    input seq_count, input ack_flags, input service_type, input service_subtype,
    input src_ident, input crc_ok, input computed_crc, input last_of_run,
    output ready
  );
endinterface

>>> design/pustc_parser.sv
module pustc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  output logic              at_last_o,
  output pustc_pkg::report_t rpt_o
);

  logic [16:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pid_q, pid_d;
  logic [15:0] seq_q, seq_d;
  logic [27:0] fhdr_q, fhdr_d;
  logic [7:0]  rx_hi_q, rx_hi_d;
  logic [16:0] total;
  logic [16:0] last_pos;
  logic [15:0] crc_next;
  logic        in_hdr;

  assign total     = (len_q < pustc_pkg::MinLen) ? pustc_pkg::ShortSize
                                                 : ({1'b0, len_q} + pustc_pkg::SizeExtra);
  assign last_pos  = total - 17'd1;
  assign in_hdr    = pos_q < pustc_pkg::PosData;
  assign at_last_o = !in_hdr && (pos_q == last_pos);
  assign crc_next  = pustc_pkg::crc_add(crc_q, byte_i);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    len_d   = len_q;
    pid_d   = pid_q;
    seq_d   = seq_q;
    fhdr_d  = fhdr_q;
    rx_hi_d = rx_hi_q;
    if (take_i) begin
      pos_d = pos_q + 17'd1;
      if (in_hdr) begin
        crc_d = crc_next;
        if (pos_q < pustc_pkg::PosSeq) begin
          pid_d = {pid_q[7:0], byte_i};
        end else if (pos_q < pustc_pkg::PosLen) begin
          seq_d = {seq_q[7:0], byte_i};
        end else if (pos_q < pustc_pkg::PosHdr) begin
          len_d = {len_q[7:0], byte_i};
        end else begin
          fhdr_d = {fhdr_q[19:0], byte_i};
        end
      end else if (pos_q < last_pos - 17'd1) begin
        crc_d = crc_next;
      end else if (!at_last_o) begin
        rx_hi_d = byte_i;
      end else begin
        pos_d = '0;
        crc_d = pustc_pkg::CrcInit;
      end
    end
  end

  // The report is only sampled on the closing byte, when the header is settled.
  assign rpt_o.pid    = pid_q;
  assign rpt_o.seq    = seq_q;
  assign rpt_o.fhdr   = fhdr_q;
  assign rpt_o.crc    = crc_q;
  assign rpt_o.crc_ok = crc_q == {rx_hi_q, byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= pustc_pkg::CrcInit;
      len_q   <= '0;
      pid_q   <= '0;
      seq_q   <= '0;
      fhdr_q  <= '0;
      rx_hi_q <= '0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      pid_q   <= pid_d;
      seq_q   <= seq_d;
      fhdr_q  <= fhdr_d;
      rx_hi_q <= rx_hi_d;
    end
  end

endmodule

>>> design/pus_telecommand_check_and_ack_unit.sv
// Telecommand check and acceptance report unit.
// The tc_i channel takes one telecommand byte per transfer, most significant
// byte first. Header fields are captured and the CRC-16 is updated in the
// cycle the byte is taken, so one can be taken in every cycle with ready high.
// When the closing byte of the error control field is taken, the report is
// latched and res_o presents fifteen results starting the next cycle: one
// field report, then the fourteen acceptance telemetry bytes, the last one
// flagged by last_of_run.
// Bytes of the following packet keep flowing in while the run is emitted.
// Only the closing byte of that packet waits, with tc_i.ready low, until the
// previous run has fully left; this is set by the single report register.
// A stall on res_o holds the current result and does not stop the byte parser.
// The configuration port sets the telemetry APID and destination; the user
// must keep it written only while the unit is idle; the unit does not enforce
// this. Reset clears the parser and run state and restores config defaults.
`include "pus_telecommand_check_and_ack_unit_assert.svh"

module pus_telecommand_check_and_ack_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  pustc_byte_if.sink  tc_i,
  pustc_res_if.source res_o
);

  logic [10:0] tm_apid_q;
  logic [7:0]  tm_dest_q;
  logic        take;
  logic        at_last;
  logic        busy_q;
  logic [pustc_pkg::IdxW-1:0] idx_q;
  logic        out_xfer;
  logic        run_done;
  logic        is_tm;
  logic [7:0]  tm_byte;
  pustc_pkg::report_t rpt, rpt_q;

  pustc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .byte_i    (tc_i.tc_byte),
    .at_last_o (at_last),
    .rpt_o     (rpt)
  );

  assign tc_i.ready = !(at_last && busy_q);
  assign take       = tc_i.valid && tc_i.ready;
  assign out_xfer   = res_o.valid && res_o.ready;
  assign run_done   = idx_q == pustc_pkg::IdxW'(pustc_pkg::TmBytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_apid_q <= pustc_pkg::TmApidReset;
      tm_dest_q <= pustc_pkg::TmDestReset;
    end else if (cfg_we_i) begin
      unique case (pustc_pkg::cfg_idx_e'(cfg_idx_i))
        pustc_pkg::CFG_TM_APID: tm_apid_q <= cfg_wdata_i;
        pustc_pkg::CFG_TM_DEST: tm_dest_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (take && at_last) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_xfer) begin
      busy_q <= !run_done;
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && at_last) begin
      rpt_q <= rpt;
    end
  end

  always_comb begin
    case (idx_q)
      4'd1:    tm_byte = {5'b00001, tm_apid_q[10:8]};
      4'd2:    tm_byte = tm_apid_q[7:0];
      4'd3:    tm_byte = rpt_q.seq[15:8];
      4'd4:    tm_byte = rpt_q.seq[7:0];
      4'd5:    tm_byte = pustc_pkg::TmLenHi;
      4'd6:    tm_byte = pustc_pkg::TmLenLo;
      4'd7:    tm_byte = pustc_pkg::TmHdr0;
      4'd8:    tm_byte = pustc_pkg::TmHdr1;
      4'd9:    tm_byte = pustc_pkg::TmHdr2;
      4'd10:   tm_byte = tm_dest_q;
      4'd11:   tm_byte = rpt_q.pid[15:8];
      4'd12:   tm_byte = rpt_q.pid[7:0];
      4'd13:   tm_byte = rpt_q.seq[15:8];
      4'd14:   tm_byte = rpt_q.seq[7:0];
      default: tm_byte = 8'h00;
    endcase
  end

  assign is_tm = idx_q != '0;

  assign res_o.valid           = busy_q;
  assign res_o.out_kind        = is_tm ? pustc_pkg::KIND_TM : pustc_pkg::KIND_REPORT;
  assign res_o.tm_byte         = tm_byte;
  assign res_o.apid            = is_tm ? 11'd0 : rpt_q.pid[10:0];
  assign res_o.seq_flags       = is_tm ? 2'd0 : rpt_q.seq[15:14];
  assign res_o.seq_count       = is_tm ? 14'd0 : rpt_q.seq[13:0];
  assign res_o.ack_flags       = is_tm ? 4'd0 : rpt_q.fhdr[27:24];
  assign res_o.service_type    = is_tm ? 8'd0 : rpt_q.fhdr[23:16];
  assign res_o.service_subtype = is_tm ? 8'd0 : rpt_q.fhdr[15:8];
  assign res_o.src_ident       = is_tm ? 8'd0 : rpt_q.fhdr[7:0];
  assign res_o.crc_ok          = is_tm ? 1'b0 : rpt_q.crc_ok;
  assign res_o.computed_crc    = is_tm ? 16'd0 : rpt_q.crc;
  assign res_o.last_of_run     = run_done;

  `PUSTC_ASSERT(a_close_loads_report, (take && at_last) |=> (busy_q && !is_tm), "run not started")
  `PUSTC_ASSERT(a_run_ends_idle, (out_xfer && run_done) |=> !res_o.valid, "run did not end")
  `PUSTC_ASSERT(a_no_overrun, (tc_i.valid && at_last && busy_q) |-> !take, "report overwritten")
  `PUSTC_ASSERT_HOLD(a_res_hold, res_o.valid, res_o.ready, res_o.tm_byte, "result changed")

endmodule
